### rtl/ftd_pkg.sv
// ftd_pkg: shared types, constants and helper functions for the float to decimal text block
// used by ftd_front, ftd_back and float_to_decimal_text_top; no dependencies
package ftd_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int NUM_DIGITS = 10;

  localparam logic [7:0]  EXP_MAX   = 8'hff;
  localparam logic [7:0]  EXP_PIVOT = 8'd158;
  localparam logic [31:0] M_TOP     = 32'h8000_0000;
  localparam logic [31:0] M_LOW     = 32'h1900_0000;
  localparam logic [31:0] RECIP10   = 32'hcccc_cccd;
  localparam logic [5:0]  PREC_RST  = 6'd6;
  localparam logic [5:0]  MAX_SIG   = 6'd9;

  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_E     = 7'h65;
  localparam logic [6:0] CH_I     = 7'h49;
  localparam logic [6:0] CH_N_LO  = 7'h6e;
  localparam logic [6:0] CH_F     = 7'h66;
  localparam logic [6:0] CH_N_UP  = 7'h4e;
  localparam logic [6:0] CH_A     = 7'h61;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {K_ZERO, K_INF, K_NAN, K_NORM} kind_t;

  typedef struct packed {
    logic        sign;
    kind_t       kind;
    logic [7:0]  ex;
    logic [22:0] mant;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SIGN, S_SPEC, S_SCALE, S_DIV, S_DIGIT, S_NORM, S_ROUND, S_TRIM,
    S_PDIG, S_PDOT, S_PZERO, S_LZ0, S_LDOT, S_LZ1, S_FDIG,
    S_XD0, S_XDOT, S_XE, S_XM, S_XT, S_XO
  } state_t;

  function automatic logic [6:0] spec_char(kind_t k, logic [1:0] idx);
    logic [6:0] c;
    c = CH_0;
    case (k)
      K_INF: begin
        case (idx)
          2'd0:    c = CH_I;
          2'd1:    c = CH_N_LO;
          default: c = CH_F;
        endcase
      end
      K_NAN: begin
        case (idx)
          2'd1:    c = CH_A;
          default: c = CH_N_UP;
        endcase
      end
      default: c = CH_0;
    endcase
    return c;
  endfunction

  function automatic digit_t tens_of(logic [6:0] v);
    digit_t t;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) t = 4'(k);
    end
    return t;
  endfunction

endpackage

### rtl/ftd_front.sv
// ftd_front: accepts float words, classifies them and holds them in a short queue
// depends on ftd_pkg
module ftd_front import ftd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [31:0]       float_bits,
  input  logic              pop,
  output qhead_t            head,
  output logic [QCNT_W-1:0] fill
);

  item_t             qmem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  item_t             cls;
  logic              push, take;
  logic [7:0]        ex;
  logic [22:0]       mant;
  logic              is_nan, is_zero;

  always_comb begin
    ex       = float_bits[30:23];
    mant     = float_bits[22:0];
    is_nan   = (ex == EXP_MAX) && (mant != 23'd0);
    is_zero  = (ex == 8'd0) && (mant == 23'd0);
    cls.sign = float_bits[31] && !is_nan && !is_zero;
    cls.ex   = ex;
    cls.mant = mant;
    if (ex == 8'd0) begin
      cls.kind = K_ZERO;
    end else if (ex == EXP_MAX) begin
      cls.kind = (mant == 23'd0) ? K_INF : K_NAN;
    end else begin
      cls.kind = K_NORM;
    end
  end

  assign item_stall = (fill == QCNT_W'(QDEPTH));
  assign push       = item_valid && !item_stall;
  assign head.valid = (fill != '0);
  assign head.item  = qmem[rp];
  assign take       = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (take) rp <= rp + 1'b1;
      fill <= fill + QCNT_W'(push) - QCNT_W'(take);
    end
  end

endmodule

### rtl/ftd_back.sv
// ftd_back: scales the mantissa, extracts and rounds digits and emits the text
// depends on ftd_pkg; fed from ftd_front
module ftd_back import ftd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  qhead_t     head,
  output logic       pop,
  input  logic [5:0] precision,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [6:0] char_code,
  output logic       last
);

  state_t            state, state_next;
  kind_t             kind, kind_next;
  logic [31:0]       m, m_next;
  logic signed [7:0] e10, e10_next;
  logic [7:0]        i, i_next, lim, lim_next;
  logic              up, up_next;
  logic              xmode, xmode_next;
  logic [5:0]        cnt, cnt_next;
  logic [3:0]        ncnt, ncnt_next;
  digit_t            dg [NUM_DIGITS];
  digit_t            dg_next [NUM_DIGITS];
  digit_t            rnd [NUM_DIGITS];

  logic [63:0]       prod;
  logic [31:0]       q32, q10, remw, m10;
  logic              far;
  logic [5:0]        prec_eff;
  logic [3:0]        nsel, tn;
  logic              carry, ovf, all9, plain;
  logic [7:0]        eabs8;
  logic [6:0]        eabs;
  digit_t            tens, ones;
  logic [6:0]        ovl;
  logic              take, emit, elast, ld;
  logic [6:0]        ech;

  // shared divide-by-ten
  always_comb begin
    prod = {32'd0, m} * {32'd0, RECIP10};
    q32  = {3'd0, prod[63:35]};
    q10  = {q32[28:0], 3'd0} + {q32[30:0], 1'b0};
    remw = m - q10;
    m10  = {m[28:0], 3'd0} + {m[30:0], 1'b0};
    far  = ({1'b0, i} + 9'd2) < {1'b0, lim};
  end

  // rounding, trimming and exponent digits
  always_comb begin
    prec_eff = (precision == 6'd0) ? 6'd1 : precision;
    nsel     = (prec_eff > MAX_SIG) ? MAX_SIG[3:0] : prec_eff[3:0];
    carry    = dg[nsel] >= 4'd5;
    ovf      = 1'b0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      all9 = 1'b1;
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (j > k && 4'(j) < nsel && dg[j] != 4'd9) all9 = 1'b0;
      end
      if (4'(k) >= nsel) begin
        rnd[k] = 4'd0;
      end else if (carry && all9) begin
        rnd[k] = (dg[k] == 4'd9) ? 4'd0 : dg[k] + 4'd1;
      end else begin
        rnd[k] = dg[k];
      end
      if (k == 0) ovf = carry && all9 && (dg[0] == 4'd9);
    end
    if (ovf) begin
      rnd[0] = 4'd1;
    end
    tn = 4'd1;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (dg[k] != 4'd0) tn = 4'(k + 1);
    end
    plain = (e10 >= -8'sd2) && (e10 < $signed({2'b0, prec_eff}));
    eabs8 = (e10 < 0) ? -e10 : e10;
    eabs  = eabs8[6:0];
    tens  = tens_of(eabs);
    ovl   = eabs - {tens, 3'd0} - {2'd0, tens, 1'b0};
    ones  = ovl[3:0];
  end

  assign take = !char_valid || !char_stall;

  always_comb begin
    state_next = state;
    kind_next  = kind;
    m_next     = m;
    e10_next   = e10;
    i_next     = i;
    lim_next   = lim;
    up_next    = up;
    xmode_next = xmode;
    cnt_next   = cnt;
    ncnt_next  = ncnt;
    dg_next    = dg;
    pop        = 1'b0;
    emit       = 1'b0;
    elast      = 1'b0;
    ech        = CH_0;
    ld         = (cnt == 6'(ncnt) - 6'd1);
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          kind_next  = head.item.kind;
          m_next     = {1'b1, head.item.mant, 8'd0};
          e10_next   = 8'sd0;
          i_next     = 8'd0;
          up_next    = head.item.ex > EXP_PIVOT;
          lim_next   = (head.item.ex > EXP_PIVOT) ? head.item.ex - EXP_PIVOT
                                                  : EXP_PIVOT - head.item.ex;
          cnt_next   = 6'd0;
          if (head.item.sign) state_next = S_SIGN;
          else state_next = (head.item.kind == K_NORM) ? S_SCALE : S_SPEC;
        end
      end
      S_SIGN: begin
        emit = 1'b1;
        ech  = CH_MINUS;
        if (take) state_next = (kind == K_NORM) ? S_SCALE : S_SPEC;
      end
      S_SPEC: begin
        emit  = 1'b1;
        ech   = spec_char(kind, cnt[1:0]);
        elast = (kind == K_ZERO) || (cnt == 6'd2);
        if (take) begin
          cnt_next = cnt + 6'd1;
          if (elast) state_next = S_IDLE;
        end
      end
      S_SCALE: begin
        if (i >= lim) begin
          cnt_next = 6'd0;
          if (m == 32'd0) begin
            kind_next  = K_ZERO;
            state_next = S_SPEC;
          end else begin
            state_next = S_DIGIT;
          end
        end else if (up) begin
          if (m >= M_TOP) begin
            state_next = S_DIV;
          end else begin
            m_next = {m[30:0], 1'b0};
            i_next = i + 8'd1;
          end
        end else if (m < M_LOW) begin
          m_next   = far ? (m10 >> 3) : (m10 >> 1);
          e10_next = e10 - 8'sd1;
          i_next   = far ? i + 8'd3 : i + 8'd1;
        end else begin
          m_next = m >> 1;
          i_next = i + 8'd1;
        end
      end
      S_DIV: begin
        m_next     = far ? (q32 << 3) : (q32 << 1);
        e10_next   = e10 + 8'sd1;
        i_next     = far ? i + 8'd3 : i + 8'd1;
        state_next = S_SCALE;
      end
      S_DIGIT: begin
        dg_next[0] = remw[3:0];
        for (int k = 1; k < NUM_DIGITS; k++) dg_next[k] = dg[k-1];
        m_next   = q32;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(NUM_DIGITS - 1)) begin
          e10_next   = e10 + 8'sd9;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (dg[0] == 4'd0) begin
          for (int k = 0; k < NUM_DIGITS - 1; k++) dg_next[k] = dg[k+1];
          dg_next[NUM_DIGITS-1] = 4'd0;
          e10_next = e10 - 8'sd1;
        end else begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        dg_next    = rnd;
        if (ovf) e10_next = e10 + 8'sd1;
        ncnt_next  = nsel;
        state_next = S_TRIM;
      end
      S_TRIM: begin
        ncnt_next  = tn;
        xmode_next = !plain;
        cnt_next   = 6'd0;
        if (!plain) state_next = S_XD0;
        else state_next = (e10 >= 0) ? S_PDIG : S_LZ0;
      end
      S_PDIG: begin
        emit  = 1'b1;
        ech   = CH_0 + {3'd0, dg[0]};
        elast = ld && !(e10 >= $signed({4'd0, ncnt}));
        if (take) begin
          for (int k = 0; k < NUM_DIGITS - 1; k++) dg_next[k] = dg[k+1];
          dg_next[NUM_DIGITS-1] = 4'd0;
          cnt_next = cnt + 6'd1;
          if (ld) state_next = elast ? S_IDLE : S_PZERO;
          else if ($signed({2'd0, cnt}) == e10) state_next = S_PDOT;
        end
      end
      S_PDOT: begin
        emit = 1'b1;
        ech  = CH_DOT;
        if (take) state_next = S_PDIG;
      end
      S_PZERO: begin
        emit  = 1'b1;
        ech   = CH_0;
        elast = $signed({2'd0, cnt}) == e10;
        if (take) begin
          cnt_next = cnt + 6'd1;
          if (elast) state_next = S_IDLE;
        end
      end
      S_LZ0: begin
        emit = 1'b1;
        ech  = CH_0;
        if (take) state_next = S_LDOT;
      end
      S_LDOT: begin
        emit = 1'b1;
        ech  = CH_DOT;
        if (take) state_next = (e10 == -8'sd2) ? S_LZ1 : S_FDIG;
      end
      S_LZ1: begin
        emit = 1'b1;
        ech  = CH_0;
        if (take) state_next = S_FDIG;
      end
      S_FDIG: begin
        emit  = 1'b1;
        ech   = CH_0 + {3'd0, dg[0]};
        elast = ld && (!xmode || e10 == 8'sd0);
        if (take) begin
          for (int k = 0; k < NUM_DIGITS - 1; k++) dg_next[k] = dg[k+1];
          dg_next[NUM_DIGITS-1] = 4'd0;
          cnt_next = cnt + 6'd1;
          if (ld) state_next = elast ? S_IDLE : S_XE;
        end
      end
      S_XD0: begin
        emit = 1'b1;
        ech  = CH_0 + {3'd0, dg[0]};
        if (take) begin
          for (int k = 0; k < NUM_DIGITS - 1; k++) dg_next[k] = dg[k+1];
          dg_next[NUM_DIGITS-1] = 4'd0;
          cnt_next   = 6'd1;
          state_next = S_XDOT;
        end
      end
      S_XDOT: begin
        emit  = 1'b1;
        ech   = CH_DOT;
        elast = (ncnt == 4'd1) && (e10 == 8'sd0);
        if (take) begin
          if (ncnt > 4'd1) state_next = S_FDIG;
          else state_next = elast ? S_IDLE : S_XE;
        end
      end
      S_XE: begin
        emit = 1'b1;
        ech  = CH_E;
        if (take) begin
          if (e10 < 0) state_next = S_XM;
          else state_next = (tens != 4'd0) ? S_XT : S_XO;
        end
      end
      S_XM: begin
        emit = 1'b1;
        ech  = CH_MINUS;
        if (take) state_next = (tens != 4'd0) ? S_XT : S_XO;
      end
      S_XT: begin
        emit = 1'b1;
        ech  = CH_0 + {3'd0, tens};
        if (take) state_next = S_XO;
      end
      S_XO: begin
        emit  = 1'b1;
        ech   = CH_0 + {3'd0, ones};
        elast = 1'b1;
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit && take) char_valid <= 1'b1;
      else if (!char_stall) char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    kind  <= kind_next;
    m     <= m_next;
    e10   <= e10_next;
    i     <= i_next;
    lim   <= lim_next;
    up    <= up_next;
    xmode <= xmode_next;
    cnt   <= cnt_next;
    ncnt  <= ncnt_next;
    dg    <= dg_next;
    if (emit && take) begin
      char_code <= ech;
      last      <= elast;
    end
  end

endmodule

### rtl/float_to_decimal_text_top.sv
// float_to_decimal_text_top: one single-precision word in, its decimal text out a char a transfer
// the first digit follows the sign, the scaling loop, digit extraction, normalising, rounding and trimming,
// then one char per cycle while char_stall is low; the scaling loop sets the rate
// the back end works on one word at a time and takes the next from the queue when idle;
// zero, inf and nan words skip the scaling loop; queue holds two words
// reset: precision returns to 6, queue empties, no clearing pass
// depends on ftd_pkg, ftd_front, ftd_back
module float_to_decimal_text_top import ftd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] float_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  precision,
  output logic        char_valid,
  input  logic        char_stall,
  output logic [6:0]  char_code,
  output logic        last
);

  logic [5:0]        prec;
  qhead_t            head;
  logic              pop;
  logic [QCNT_W-1:0] fill;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= PREC_RST;
    end else if (cfg_valid && cfg_ready) begin
      prec <= precision;
    end
  end

  ftd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .float_bits (float_bits),
    .pop        (pop),
    .head       (head),
    .fill       (fill)
  );

  ftd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .precision  (prec),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last       (last)
  );

  a_reset_quiet: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("char_valid after reset");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> fill != '0)
    else $error("accepted word missing from queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop && head.valid |-> fill != '0)
    else $error("pop from empty queue");

endmodule

### dv/float_to_decimal_text_top_tb.sv
// float_to_decimal_text_top_tb: self-checking bench for the float to decimal text block
// predicts the ascii text of each accepted word and checks every char transfer in order
// depends on ftd_pkg and float_to_decimal_text_top
module float_to_decimal_text_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ftd_pkg::*;

  typedef struct {
    bit [6:0] code;
    bit       fin;
  } text_char_t;

  class text_scoreboard;
    text_char_t pending[$];
    int mismatches;
    int cfg_prec;

    function new();
      mismatches = 0;
      cfg_prec = PREC_RST;
    endfunction

    function void put_char(bit [6:0] c, ref text_char_t buf_q[$]);
      text_char_t t;
      if (buf_q.size() < 42) begin
        t.code = c;
        t.fin = 0;
        buf_q.push_back(t);
      end
    endfunction

    function void format_normal(bit [7:0] ex, bit [22:0] mant, ref text_char_t buf_q[$]);
      int e, e10, i, k, z, n, prec, q;
      bit [31:0] m, r;
      int s[10];
      bit carry;
      e = int'(ex) - 158;
      m = ({9'b0, mant} | 32'h0080_0000) << 8;
      e10 = 0;
      if (e > 0) begin
        for (i = 0; i < e; i++) begin
          if (m >= M_TOP) begin
            m = m / 10;
            e10++;
            if (i + 2 < e) begin
              m = m << 2;
              i += 2;
            end
          end
          m = m << 1;
        end
      end else begin
        k = -e;
        for (i = 0; i < k; i++) begin
          if (m < M_LOW) begin
            m = m * 10;
            e10--;
            if (i + 2 < k) begin
              m = m >> 2;
              i += 2;
            end
          end
          m = m >> 1;
        end
      end
      if (m == 0) begin
        put_char(CH_0, buf_q);
        return;
      end
      r = m;
      for (i = 9; i >= 0; i--) begin
        s[i] = r % 10;
        r = r / 10;
      end
      z = 0;
      while (z < 10 && s[z] == 0) z++;
      for (i = 0; i < 10 - z; i++) s[i] = s[i + z];
      for (i = 10 - z; i < 10; i++) s[i] = 0;
      e10 += 9 - z;
      prec = (cfg_prec == 0) ? 1 : cfg_prec;
      n = (prec < 9) ? prec : 9;
      carry = (s[n] >= 5);
      s[n] = 0;
      if (carry) begin
        for (i = n - 1; i >= 0; i--) begin
          s[i]++;
          if (s[i] == 10) s[i] = 0;
          else begin
            carry = 0;
            break;
          end
        end
        if (carry) begin
          s[0] = 1;
          for (i = 1; i < 10; i++) s[i] = 0;
          e10++;
        end
      end
      for (i = n - 1; i > 0; i--) begin
        if (s[i] == 0) n--;
        else break;
      end
      if (e10 >= -2 && e10 < prec) begin
        if (e10 >= 0) begin
          for (i = 0; i < n; i++) begin
            put_char(CH_0 + 7'(s[i]), buf_q);
            if (i == e10 && i != n - 1) put_char(CH_DOT, buf_q);
          end
          for (i = n; i <= e10; i++) put_char(CH_0, buf_q);
        end else begin
          put_char(CH_0, buf_q);
          put_char(CH_DOT, buf_q);
          if (e10 == -2) put_char(CH_0, buf_q);
          for (i = 0; i < n; i++) put_char(CH_0 + 7'(s[i]), buf_q);
        end
      end else begin
        put_char(CH_0 + 7'(s[0]), buf_q);
        put_char(CH_DOT, buf_q);
        for (i = 1; i < n; i++) put_char(CH_0 + 7'(s[i]), buf_q);
        if (e10 != 0) begin
          put_char(CH_E, buf_q);
          if (e10 < 0) begin
            put_char(CH_MINUS, buf_q);
            e10 = -e10;
          end
          q = e10 / 10;
          if (q != 0) put_char(CH_0 + 7'(q % 10), buf_q);
          put_char(CH_0 + 7'(e10 % 10), buf_q);
        end
      end
    endfunction

    function void note_word(bit [31:0] w);
      text_char_t txt[$];
      bit [7:0] ex;
      bit [22:0] mant;
      ex = w[30:23];
      mant = w[22:0];
      if (w[31] && !(ex == EXP_MAX && mant != 0) && !(ex == 0 && mant == 0))
        put_char(CH_MINUS, txt);
      if (ex == 0) put_char(CH_0, txt);
      else if (ex == EXP_MAX) begin
        if (mant == 0) begin
          put_char(CH_I, txt);
          put_char(CH_N_LO, txt);
          put_char(CH_F, txt);
        end else begin
          put_char(CH_N_UP, txt);
          put_char(CH_A, txt);
          put_char(CH_N_UP, txt);
        end
      end else format_normal(ex, mant, txt);
      txt[txt.size() - 1].fin = 1;
      foreach (txt[i]) pending.push_back(txt[i]);
    endfunction

    function void check_char(bit [6:0] code, bit fin);
      text_char_t exp_c;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected char %h last %b", code, fin);
        return;
      end
      exp_c = pending.pop_front();
      if (exp_c.code !== code || exp_c.fin !== fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("char mismatch: expected %h last %b, got %h last %b",
                   exp_c.code, exp_c.fin, code, fin);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        item_valid = 0;
  logic        item_stall;
  logic [31:0] float_bits = '0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [5:0]  precision = '0;
  logic        char_valid;
  logic        char_stall = 0;
  logic [6:0]  char_code;
  logic        last;

  text_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  float_to_decimal_text_top uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .float_bits(float_bits),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .precision(precision),
    .char_valid(char_valid), .char_stall(char_stall),
    .char_code(char_code), .last(last)
  );

  always #5 clk = ~clk;

  // receiver side and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) sb.check_char(char_code, last);
      if ((char_valid && !char_stall) || (item_valid && !item_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
    char_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(bit [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    float_bits <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic write_precision(bit [5:0] v);
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1;
    precision <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.cfg_prec = v;
  endtask

  function automatic bit [31:0] rand_word();
    bit [31:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(9);
    case (pick)
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hff;
      2: w[30:23] = 8'(127 + $urandom_range(40) - 20);
      3: w[22:0] = ($urandom_range(1)) ? 23'h7fffff : 23'h0;
      4: w[30:23] = 8'(127 + $urandom_range(60) - 30);
      default: ;
    endcase
    return w;
  endfunction

  bit [31:0] directed[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff, 32'h7f80_0000,
    32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff, 32'h7f7f_ffff, 32'hff7f_ffff,
    32'h0080_0000, 32'h3f80_0000, 32'h3c23_d70a, 32'h3a83_126f, 32'h411f_ffff,
    32'h3f00_0000, 32'h42c8_0000, 32'h4b18_9680, 32'h47f1_2039, 32'hbf7f_ffff,
    32'h3dcc_cccd, 32'h4e6e_6b28, 32'h0100_0000
  };
  bit [5:0] prec_list[8] = '{6'd6, 6'd1, 6'd9, 6'd40, 6'd0, 6'd63, 6'd3, 6'd12};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i]);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) write_precision(prec_list[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph == 1) foreach (directed[i]) send_word(directed[i]);
      for (int n = 0; n < 40; n++) send_word(rand_word());
    end
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/ftd_pkg.sv
rtl/ftd_front.sv
rtl/ftd_back.sv
rtl/float_to_decimal_text_top.sv
dv/float_to_decimal_text_top_tb.sv
